[sv/hglk_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the high-pass gain limiter.
// No dependencies.
package hglk_pkg;

	localparam int LOOKAHEAD_LEN_DEF  = 64;
	localparam int ATTACK_FACTOR_DEF  = 32768;
	localparam int RECOVER_FACTOR_DEF = 66;

	localparam int IN_QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 18;
	localparam int LINE_W         = 26;

	localparam logic [16:0] UNITY_Q16 = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_HP_B0    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_B1    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HP_B2    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HP_A1    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HP_A2    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SEL = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 4'd7;

	typedef struct packed {
		logic signed [17:0] b0;
		logic signed [17:0] b1;
		logic signed [17:0] b2;
		logic signed [17:0] a1;
		logic signed [17:0] a2;
		logic [2:0]         gain_sel;
		logic [14:0]        ceiling;
		logic [15:0]        release_f;
	} cfg_t;

	function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
		logic signed [39:0] r;
		if (v[47:39] != {9{v[47]}}) begin
			r = v[47] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	function automatic logic [2:0] gain_shift(input logic [2:0] sel);
		logic [2:0] s;
		case (sel)
			3'd1: s = 3'd3;
			3'd2: s = 3'd5;
			3'd3: s = 3'd6;
			3'd4: s = 3'd7;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

[sv/hglk_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module hglk_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/hglk_front.sv]
`timescale 1ns / 1ps
// Input side: accepts samples and holds them in a short queue for the back end.
// Depends on hglk_pkg.
module hglk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] mic_sample,
	output logic               q_valid,
	output logic signed [15:0] q_data,
	input  logic               q_pop
);
	import hglk_pkg::*;

	localparam int PW = $clog2(IN_QUEUE_DEPTH);

	logic signed [15:0] buf_q [IN_QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(IN_QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= mic_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[sv/hglk_back.sv]
`timescale 1ns / 1ps
// Back end sequencer: biquad, gain, envelope, divider, smoothing, lookahead line.
// Depends on hglk_pkg and hglk_ram.
module hglk_back #(
	parameter int LOOKAHEAD_LEN      = hglk_pkg::LOOKAHEAD_LEN_DEF,
	parameter int ATTACK_FACTOR_Q16  = hglk_pkg::ATTACK_FACTOR_DEF,
	parameter int RECOVER_FACTOR_Q16 = hglk_pkg::RECOVER_FACTOR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hglk_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  logic signed [15:0] q_data,
	output logic               q_pop,
	input  logic               slot_free,
	output logic               res_valid,
	output logic signed [15:0] res_data
);
	import hglk_pkg::*;

	localparam int AW = (LOOKAHEAD_LEN > 1) ? $clog2(LOOKAHEAD_LEN) : 1;
	localparam int HW = $clog2(LOOKAHEAD_LEN + 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_Y    = 5'd1;
	localparam logic [4:0] ST_B1   = 5'd2;
	localparam logic [4:0] ST_B2   = 5'd3;
	localparam logic [4:0] ST_A1L  = 5'd4;
	localparam logic [4:0] ST_A1H  = 5'd5;
	localparam logic [4:0] ST_A2L  = 5'd6;
	localparam logic [4:0] ST_A2H  = 5'd7;
	localparam logic [4:0] ST_ENV  = 5'd8;
	localparam logic [4:0] ST_REL  = 5'd9;
	localparam logic [4:0] ST_DSET = 5'd10;
	localparam logic [4:0] ST_DIV  = 5'd11;
	localparam logic [4:0] ST_GAIN = 5'd12;
	localparam logic [4:0] ST_GMUL = 5'd13;
	localparam logic [4:0] ST_STEP = 5'd14;
	localparam logic [4:0] ST_OMUL = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	logic [4:0] state_q;

	logic signed [15:0] x_q;
	logic signed [39:0] z1_q, z2_q, y_q;
	logic signed [33:0] t1_q, t2_q;
	logic signed [38:0] acc_q;
	logic signed [LINE_W-1:0] gained_q;
	logic [31:0] env_q;
	logic [HW-1:0] hold_q;
	logic decay_q;
	logic [32:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  dcnt_q;
	logic [16:0] target_q, gain_q, diff_q;
	logic dir_q;
	logic [AW-1:0] pos_q;
	logic wrapped_q;
	logic signed [15:0] res_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	logic signed [LINE_W-1:0] rd_data, delayed;
	logic ram_we;

	logic signed [59:0] full_fb;
	logic signed [47:0] y_sum, z1_sum, z2_sum;
	logic signed [18:0] ys;
	logic signed [LINE_W-1:0] gained;
	logic [LINE_W-1:0] gmag;
	logic [31:0] mag;
	logic [20:0] ceil_q6;
	logic [32:0] rem2;
	logic        div_bit;
	logic [18:0] stepv;
	logic [16:0] step;
	logic [43:0] pm;
	logic [27:0] qv;
	logic signed [15:0] value;

	hglk_ram #(.WIDTH(LINE_W), .DEPTH(LOOKAHEAD_LEN), .AW(AW)) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(gained_q),
		.raddr(pos_q),
		.rdata(rd_data)
	);

	assign delayed = wrapped_q ? rd_data : '0;
	assign ram_we  = (state_q == ST_OUT);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin mul_a = 33'(cfg.b0); mul_b = 33'(q_data); end
			ST_Y:    begin mul_a = 33'(cfg.b1); mul_b = 33'(x_q); end
			ST_B1:   begin mul_a = 33'(cfg.b2); mul_b = 33'(x_q); end
			ST_B2:   begin mul_a = 33'(cfg.a1); mul_b = $signed({13'd0, y_q[19:0]}); end
			ST_A1L:  begin mul_a = 33'(cfg.a1); mul_b = 33'($signed(y_q[39:20])); end
			ST_A1H:  begin mul_a = 33'(cfg.a2); mul_b = $signed({13'd0, y_q[19:0]}); end
			ST_A2L:  begin mul_a = 33'(cfg.a2); mul_b = 33'($signed(y_q[39:20])); end
			ST_ENV:  begin
				mul_a = $signed({1'b0, env_q});
				mul_b = $signed({17'd0, cfg.release_f});
			end
			ST_GMUL: begin
				mul_a = $signed({16'd0, diff_q});
				mul_b = dir_q ? $signed({16'd0, 17'(ATTACK_FACTOR_Q16)})
				              : $signed({16'd0, 17'(RECOVER_FACTOR_Q16)});
			end
			ST_OMUL: begin mul_a = 33'(delayed); mul_b = $signed({16'd0, gain_q}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_comb begin
		full_fb = $signed({prod_q[39:0], 20'd0}) + 60'(acc_q);
		y_sum   = 48'($signed(prod_q[33:0])) + 48'(z1_q);
		z1_sum  = 48'(t1_q) - 48'($signed(full_fb[59:16])) + 48'(z2_q);
		z2_sum  = 48'(t2_q) - 48'($signed(full_fb[59:16]));

		if (y_q[39:34] != {6{y_q[39]}}) begin
			ys = y_q[39] ? {1'b1, 18'd0} : {1'b0, {18{1'b1}}};
		end else begin
			ys = y_q[34:16];
		end
		gained = LINE_W'(ys) <<< gain_shift(cfg.gain_sel);
		gmag   = gained_q[LINE_W-1] ? LINE_W'(-gained_q) : LINE_W'(gained_q);
		mag    = {gmag, 6'd0};

		ceil_q6 = {cfg.ceiling, 6'd0};
		rem2    = {rem_q[31:0], 1'b0};
		div_bit = (rem2 >= {1'b0, env_q});

		stepv = 19'((prod_q[34:0] + 35'd65535) >> 16);
		step  = (stepv > {2'b0, diff_q}) ? diff_q : stepv[16:0];

		pm = prod_q[43] ? 44'(-prod_q[43:0]) : prod_q[43:0];
		qv = pm[43:16];
		if (prod_q[43]) begin
			value = (qv > 28'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, qv}));
		end else begin
			value = (qv > 28'd32767) ? 16'sd32767 : $signed(qv[15:0]);
		end
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign res_valid = (state_q == ST_DONE) && slot_free;
	assign res_data  = res_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: x_q <= q_data;
			ST_Y:    y_q <= sat40(y_sum);
			ST_B1:   t1_q <= prod_q[33:0];
			ST_B2:   t2_q <= prod_q[33:0];
			ST_A1L:  acc_q <= prod_q[38:0];
			ST_A2L:  acc_q <= prod_q[38:0];
			ST_A2H:  gained_q <= gained;
			ST_DSET: begin rem_q <= 33'(ceil_q6); dcnt_q <= '0; end
			ST_DIV:  begin
				rem_q  <= div_bit ? rem2 - {1'b0, env_q} : rem2;
				quo_q  <= {quo_q[14:0], div_bit};
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_GAIN: begin
				dir_q  <= (target_q < gain_q);
				diff_q <= (target_q < gain_q) ? gain_q - target_q : target_q - gain_q;
			end
			ST_OUT:  res_q <= value;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			z1_q      <= '0;
			z2_q      <= '0;
			env_q     <= '0;
			hold_q    <= '0;
			decay_q   <= 1'b0;
			target_q  <= UNITY_Q16;
			gain_q    <= UNITY_Q16;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_Y;
				ST_Y:    state_q <= ST_B1;
				ST_B1:   state_q <= ST_B2;
				ST_B2:   state_q <= ST_A1L;
				ST_A1L:  state_q <= ST_A1H;
				ST_A1H:  begin
					z1_q    <= sat40(z1_sum);
					state_q <= ST_A2L;
				end
				ST_A2L:  state_q <= ST_A2H;
				ST_A2H:  begin
					z2_q    <= sat40(z2_sum);
					state_q <= ST_ENV;
				end
				ST_ENV:  begin
					decay_q <= 1'b0;
					if (mag > env_q) begin
						env_q  <= mag;
						hold_q <= HW'(LOOKAHEAD_LEN);
					end else if (hold_q != '0) begin
						hold_q <= hold_q - 1'b1;
					end else begin
						decay_q <= 1'b1;
					end
					state_q <= ST_REL;
				end
				ST_REL:  begin
					if (decay_q) env_q <= prod_q[47:16];
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					if (env_q > 32'(ceil_q6)) begin
						state_q <= ST_DIV;
					end else begin
						target_q <= UNITY_Q16;
						state_q  <= ST_GAIN;
					end
				end
				ST_DIV:  begin
					if (dcnt_q == 4'd15) begin
						target_q <= {1'b0, quo_q[14:0], div_bit};
						state_q  <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_GMUL;
				ST_GMUL: state_q <= ST_STEP;
				ST_STEP: begin
					gain_q  <= dir_q ? gain_q - step : gain_q + step;
					state_q <= ST_OMUL;
				end
				ST_OMUL: state_q <= ST_OUT;
				ST_OUT:  begin
					if (pos_q == AW'(LOOKAHEAD_LEN - 1)) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[sv/highpass_gain_lookahead_limiter_unit.sv]
`timescale 1ns / 1ps
// Top level: configuration registers, input queue, back end and result register.
// Depends on hglk_pkg, hglk_front, hglk_back.
//
// channel   direction  handshake        payload
// input     in         push / full      mic_sample[15:0] signed
// result    out        empty / pop      limited_sample[15:0] signed
// config    in         cfg_we           cfg_index[3:0], cfg_data[17:0]
//
// In the back end each item passes through the biquad on the shared multiplier, the
// envelope, the 16-bit restoring divider when the envelope is above the ceiling,
// and smoothing and output; the divider is skipped otherwise. A full result
// register holds the back end in its last state. Reset is asynchronous and takes
// effect at once; no clearing pass.
// A four-entry input queue and a one-entry result register let each side stall.
module highpass_gain_lookahead_limiter_unit #(
	parameter int LOOKAHEAD_LEN      = hglk_pkg::LOOKAHEAD_LEN_DEF,
	parameter int ATTACK_FACTOR_Q16  = hglk_pkg::ATTACK_FACTOR_DEF,
	parameter int RECOVER_FACTOR_Q16 = hglk_pkg::RECOVER_FACTOR_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [15:0]                  mic_sample,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [15:0]                  limited_sample,
	input  logic                                cfg_we,
	input  logic [hglk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hglk_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import hglk_pkg::*;

	cfg_t cfg_q;
	logic q_valid, q_pop, slot_free, res_valid;
	logic signed [15:0] q_data, res_data, out_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0        <= 18'sd64000;
			cfg_q.b1        <= -18'sd128000;
			cfg_q.b2        <= 18'sd64000;
			cfg_q.a1        <= -18'sd127900;
			cfg_q.a2        <= 18'sd62500;
			cfg_q.gain_sel  <= 3'd0;
			cfg_q.ceiling   <= 15'd29000;
			cfg_q.release_f <= 16'd65500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HP_B0:    cfg_q.b0        <= $signed(cfg_data);
				REG_HP_B1:    cfg_q.b1        <= $signed(cfg_data);
				REG_HP_B2:    cfg_q.b2        <= $signed(cfg_data);
				REG_HP_A1:    cfg_q.a1        <= $signed(cfg_data);
				REG_HP_A2:    cfg_q.a2        <= $signed(cfg_data);
				REG_GAIN_SEL: cfg_q.gain_sel  <= cfg_data[2:0];
				REG_CEILING:  cfg_q.ceiling   <= cfg_data[14:0];
				REG_RELEASE:  cfg_q.release_f <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	hglk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mic_sample(mic_sample),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop)
	);

	hglk_back #(
		.LOOKAHEAD_LEN     (LOOKAHEAD_LEN),
		.ATTACK_FACTOR_Q16 (ATTACK_FACTOR_Q16),
		.RECOVER_FACTOR_Q16(RECOVER_FACTOR_Q16)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.slot_free(slot_free),
		.res_valid(res_valid),
		.res_data (res_data)
	);

	assign slot_free      = !out_valid_q || pop;
	assign empty          = !out_valid_q;
	assign limited_sample = out_q;

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || pop))
		else $error("result loaded into occupied slot");

	a_res_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("back end delivered two items in consecutive cycles");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !res_valid) |=> empty)
		else $error("slot not freed after pop");

	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end took two items back to back");
endmodule
